// File: rtl/jst_pkg.sv
// ----------------------------------------------------------------------------
// jst_pkg
// Types and codes shared by the JSON stream tokenizer modules.
// ----------------------------------------------------------------------------
package jst_pkg;

  localparam int unsigned CntW   = 24;
  localparam int unsigned MaxEv  = 4;

  // event kinds
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_OBJ_OPEN = 4'd1;
  localparam logic [3:0] EV_ARR_OPEN = 4'd2;
  localparam logic [3:0] EV_CLOSE    = 4'd3;
  localparam logic [3:0] EV_KEY_BYTE = 4'd4;
  localparam logic [3:0] EV_KEY_END  = 4'd5;
  localparam logic [3:0] EV_STR_BYTE = 4'd6;
  localparam logic [3:0] EV_STR_END  = 4'd7;
  localparam logic [3:0] EV_NUM_BYTE = 4'd8;
  localparam logic [3:0] EV_NUM_END  = 4'd9;
  localparam logic [3:0] EV_TRUE     = 4'd10;
  localparam logic [3:0] EV_DOC_END  = 4'd13;
  localparam logic [3:0] EV_ERROR    = 4'd14;

  // error codes
  localparam logic [4:0] ER_COMMA_UNEXP = 5'd1;
  localparam logic [4:0] ER_COMMA_EXP   = 5'd2;
  localparam logic [4:0] ER_QUOTE       = 5'd3;
  localparam logic [4:0] ER_ESC_END     = 5'd4;
  localparam logic [4:0] ER_HEX         = 5'd5;
  localparam logic [4:0] ER_LOW_SURR    = 5'd6;
  localparam logic [4:0] ER_SURR_MISS   = 5'd7;
  localparam logic [4:0] ER_SURR_BAD    = 5'd8;
  localparam logic [4:0] ER_ESC         = 5'd9;
  localparam logic [4:0] ER_UTF8        = 5'd10;
  localparam logic [4:0] ER_INT_ZERO    = 5'd11;
  localparam logic [4:0] ER_NUM         = 5'd12;
  localparam logic [4:0] ER_FRAC        = 5'd13;
  localparam logic [4:0] ER_EXP         = 5'd14;
  localparam logic [4:0] ER_COLON       = 5'd15;
  localparam logic [4:0] ER_TOKEN       = 5'd16;
  localparam logic [4:0] ER_CLOSES      = 5'd17;
  localparam logic [4:0] ER_END         = 5'd18;
  localparam logic [4:0] ER_DEPTH       = 5'd19;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [3:0]      event_kind;
    logic [7:0]      data_byte;
    logic [4:0]      nest_depth;
    logic [4:0]      error_code;
    logic [CntW-1:0] line_number;
    logic [CntW-1:0] column_number;
    logic            last_of_run;
  } out_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
    logic [4:0] depth;
    logic [4:0] err;
  } ev_t;

  // all events caused by one input item
  typedef struct packed {
    ev_t [MaxEv-1:0] ev;
    logic [2:0]      cnt;
    logic [CntW-1:0] line;
    logic [CntW-1:0] col;
  } bundle_t;

endpackage

// File: rtl/jst_front.sv
// ----------------------------------------------------------------------------
// jst_front
// Parser: takes one byte per cycle while acc_i is high, keeps the nesting
// stack and builds the group of events that the byte causes.
// ----------------------------------------------------------------------------
module jst_front #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  jst_pkg::in_t     in_i,
  output logic             push_o,
  output jst_pkg::bundle_t bundle_o
);
  import jst_pkg::*;

  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [4:0] MD_VALUE       = 5'd0;
  localparam logic [4:0] MD_AFTER_COMMA = 5'd1;
  localparam logic [4:0] MD_COLON       = 5'd2;
  localparam logic [4:0] MD_AFTER_COLON = 5'd3;
  localparam logic [4:0] MD_STR         = 5'd4;
  localparam logic [4:0] MD_ESC         = 5'd5;
  localparam logic [4:0] MD_HEX         = 5'd6;
  localparam logic [4:0] MD_UTF8        = 5'd7;
  localparam logic [4:0] MD_PAIR_BS     = 5'd8;
  localparam logic [4:0] MD_PAIR_U      = 5'd9;
  localparam logic [4:0] MD_PAIR_HEX    = 5'd10;
  localparam logic [4:0] MD_NSIGN       = 5'd11;
  localparam logic [4:0] MD_NZERO       = 5'd12;
  localparam logic [4:0] MD_NINT        = 5'd13;
  localparam logic [4:0] MD_NFRAC0      = 5'd14;
  localparam logic [4:0] MD_NFRAC       = 5'd15;
  localparam logic [4:0] MD_NEXP0       = 5'd16;
  localparam logic [4:0] MD_NEXPS       = 5'd17;
  localparam logic [4:0] MD_NEXP        = 5'd18;
  localparam logic [4:0] MD_LIT         = 5'd19;
  localparam logic [4:0] MD_DONE        = 5'd20;

  localparam logic [1:0] FL_COMMA  = 2'b01;
  localparam logic [1:0] FL_OBJECT = 2'b10;

  function automatic ev_t ev_make(logic [3:0] k, logic [7:0] d, logic [LW-1:0] l,
                                  logic [4:0] e);
    ev_t r;
    r.kind  = k;
    r.data  = d;
    r.depth = 5'(l);
    r.err   = e;
    return r;
  endfunction

  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
    else r = 5'd0;
    return r;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] w, logic [2:0] i);
    logic [7:0] r;
    unique case ({w, i})
      {2'd0, 3'd0}: r = "t";
      {2'd0, 3'd1}: r = "r";
      {2'd0, 3'd2}: r = "u";
      {2'd0, 3'd3}: r = "e";
      {2'd1, 3'd0}: r = "f";
      {2'd1, 3'd1}: r = "a";
      {2'd1, 3'd2}: r = "l";
      {2'd1, 3'd3}: r = "s";
      {2'd1, 3'd4}: r = "e";
      {2'd2, 3'd0}: r = "n";
      {2'd2, 3'd1}: r = "u";
      {2'd2, 3'd2}: r = "l";
      {2'd2, 3'd3}: r = "l";
      default:      r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  logic [4:0]      md_q, md_d;
  logic [LW-1:0]   lv_q, lv_d;
  logic [1:0]      top_q, top_d;
  logic [1:0]      below_q;
  logic [15:0]     hex_q, hex_d;
  logic [2:0]      hcnt_q, hcnt_d;
  logic [9:0]      hs_q, hs_d;
  logic [1:0]      u8_q, u8_d;
  logic [4:0]      lit_q, lit_d;
  logic [4:0]      err_q, err_d;
  logic [CntW-1:0] line_q, line_d, col_q, col_d;
  logic            key_q, key_d;

  logic [1:0]      stack_mem [MAX_DEPTH];
  logic            push_lv;
  logic [1:0]      push_flags;
  logic [AW-1:0]   rd_addr;

  ev_t [MaxEv-1:0] ev;
  logic [2:0]      n;
  logic            do_val, do_start, do_vstart, do_endv, cp_en;
  logic [20:0]     cp;
  logic [7:0]      c;
  logic [4:0]      hv;
  logic [15:0]     acc_hex;
  logic [1:0]      lw;
  logic [2:0]      ln, wlen;
  logic            lit_ok;
  logic [3:0]      sk;

  assign c = in_i.in_byte;

  always_comb begin
    md_d = md_q; lv_d = lv_q; top_d = top_q; hex_d = hex_q; hcnt_d = hcnt_q;
    hs_d = hs_q; u8_d = u8_q; lit_d = lit_q; err_d = err_q; line_d = line_q;
    col_d = col_q; key_d = key_q;
    ev = '0; n = 3'd0; push_lv = 1'b0; push_flags = top_q;
    do_val = 1'b0; do_start = 1'b0; do_vstart = 1'b0; do_endv = 1'b0;
    cp_en = 1'b0; cp = '0;
    hv = hex_val(c);
    acc_hex = {hex_q[11:0], hv[3:0]};
    lw = lit_q[4:3];
    ln = lit_q[2:0];
    wlen = (lw == 2'd1) ? 3'd5 : 3'd4;
    lit_ok = (lw != 2'd3) && (ln == wlen);
    sk = key_q ? EV_KEY_BYTE : EV_STR_BYTE;

    if (acc_i && err_q == 5'd0 && md_q != MD_DONE) begin
      if (in_i.end_of_input) begin
        unique case (md_q)
          MD_VALUE: do_endv = 1'b1;
          MD_STR: begin
            err_d = ER_QUOTE; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
          end
          MD_ESC: begin
            err_d = ER_ESC_END; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
          end
          MD_HEX, MD_PAIR_HEX: begin
            err_d = ER_HEX; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
          end
          MD_UTF8: begin
            err_d = ER_UTF8; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
          end
          MD_PAIR_BS, MD_PAIR_U: begin
            err_d = ER_SURR_MISS; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
            n = n + 3'd1;
          end
          MD_NSIGN: begin
            err_d = ER_NUM; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
          end
          MD_NFRAC0: begin
            err_d = ER_FRAC; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
          end
          MD_NEXP0, MD_NEXPS: begin
            err_d = ER_EXP; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
          end
          MD_NZERO, MD_NINT, MD_NFRAC, MD_NEXP: begin
            ev[n[1:0]] = ev_make(EV_NUM_END, 8'h0, lv_d, err_d); n = n + 3'd1;
            md_d = MD_VALUE;
            do_endv = 1'b1;
          end
          MD_LIT: begin
            if (lit_ok) begin
              ev[n[1:0]] = ev_make(EV_TRUE + {2'b00, lw}, 8'h0, lv_d, err_d); n = n + 3'd1;
              md_d = MD_VALUE;
              do_endv = 1'b1;
            end else begin
              err_d = ER_TOKEN; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
              n = n + 3'd1;
            end
          end
          default: begin
            err_d = ER_END; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
          end
        endcase
      end else begin
        // position counters, multi-byte characters count at their lead byte
        if ((c >= 8'h20 && c < 8'h80) || c >= 8'hC0) begin
          if (col_q != '1) col_d = col_q + 1'b1;
        end else if (c == 8'h0A) begin
          if (line_q != '1) line_d = line_q + 1'b1;
          col_d = CntW'(1);
        end

        unique case (md_q)
          MD_VALUE: do_val = 1'b1;
          MD_AFTER_COMMA: do_start = !is_ws(c);
          MD_COLON: begin
            if (c == ":") md_d = MD_AFTER_COLON;
            else if (!is_ws(c)) begin
              err_d = ER_COLON; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
              n = n + 3'd1;
            end
          end
          MD_AFTER_COLON: do_vstart = !is_ws(c);
          MD_STR: begin
            if (c == 8'h22) begin
              ev[n[1:0]] = ev_make(key_q ? EV_KEY_END : EV_STR_END, 8'h0, lv_d, err_d);
              n = n + 3'd1;
              md_d = key_q ? MD_COLON : MD_VALUE;
            end else if (c == 8'h5C) begin
              md_d = MD_ESC;
            end else if (c >= 8'hF8 || (c >= 8'h80 && c < 8'hC0)) begin
              err_d = ER_UTF8; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
            end else begin
              ev[n[1:0]] = ev_make(sk, c, lv_d, err_d); n = n + 3'd1;
              if (c >= 8'hC0) begin
                u8_d = (c >= 8'hF0) ? 2'd3 : (c >= 8'hE0) ? 2'd2 : 2'd1;
                md_d = MD_UTF8;
              end
            end
          end
          MD_ESC: begin
            md_d = MD_STR;
            unique case (c)
              8'h22, 8'h5C, 8'h2F: begin
                ev[n[1:0]] = ev_make(sk, c, lv_d, err_d); n = n + 3'd1;
              end
              "b": begin ev[n[1:0]] = ev_make(sk, 8'h08, lv_d, err_d); n = n + 3'd1; end
              "f": begin ev[n[1:0]] = ev_make(sk, 8'h0C, lv_d, err_d); n = n + 3'd1; end
              "n": begin ev[n[1:0]] = ev_make(sk, 8'h0A, lv_d, err_d); n = n + 3'd1; end
              "r": begin ev[n[1:0]] = ev_make(sk, 8'h0D, lv_d, err_d); n = n + 3'd1; end
              "t": begin ev[n[1:0]] = ev_make(sk, 8'h09, lv_d, err_d); n = n + 3'd1; end
              "u": begin
                hex_d = '0; hcnt_d = '0; md_d = MD_HEX;
              end
              default: begin
                md_d = md_q;
                err_d = ER_ESC; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
                n = n + 3'd1;
              end
            endcase
          end
          MD_HEX, MD_PAIR_HEX: begin
            if (!hv[4]) begin
              err_d = ER_HEX; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
            end else begin
              hex_d = acc_hex;
              hcnt_d = hcnt_q + 3'd1;
              if (hcnt_q == 3'd3) begin
                hcnt_d = '0;
                if (md_q == MD_PAIR_HEX) begin
                  if (acc_hex < 16'hDC00 || acc_hex > 16'hDFFF) begin
                    err_d = ER_SURR_BAD; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
                    n = n + 3'd1;
                  end else begin
                    cp_en = 1'b1;
                    cp = {1'b0, hs_q, acc_hex[9:0]} + 21'h10000;
                    md_d = MD_STR;
                  end
                end else if (acc_hex >= 16'hDC00 && acc_hex <= 16'hDFFF) begin
                  err_d = ER_LOW_SURR; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
                  n = n + 3'd1;
                end else if (acc_hex >= 16'hD800 && acc_hex <= 16'hDBFF) begin
                  hs_d = acc_hex[9:0];
                  md_d = MD_PAIR_BS;
                end else begin
                  cp_en = 1'b1;
                  cp = {5'd0, acc_hex};
                  md_d = MD_STR;
                end
              end
            end
          end
          MD_UTF8: begin
            if (c < 8'h80 || c >= 8'hC0) begin
              err_d = ER_UTF8; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
            end else begin
              ev[n[1:0]] = ev_make(sk, c, lv_d, err_d); n = n + 3'd1;
              u8_d = u8_q - 2'd1;
              if (u8_q == 2'd1) md_d = MD_STR;
            end
          end
          MD_PAIR_BS: begin
            if (c == 8'h5C) md_d = MD_PAIR_U;
            else begin
              err_d = ER_SURR_MISS; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
              n = n + 3'd1;
            end
          end
          MD_PAIR_U: begin
            if (c == "u") begin
              hex_d = '0; hcnt_d = '0; md_d = MD_PAIR_HEX;
            end else begin
              err_d = ER_SURR_MISS; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
              n = n + 3'd1;
            end
          end
          MD_NSIGN, MD_NFRAC0, MD_NEXPS: begin
            if (is_dig(c)) begin
              ev[n[1:0]] = ev_make(EV_NUM_BYTE, c, lv_d, err_d); n = n + 3'd1;
              md_d = (md_q == MD_NFRAC0) ? MD_NFRAC : (md_q == MD_NEXPS) ? MD_NEXP :
                     (c == "0") ? MD_NZERO : MD_NINT;
            end else begin
              err_d = (md_q == MD_NSIGN) ? ER_NUM : (md_q == MD_NFRAC0) ? ER_FRAC : ER_EXP;
              ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
            end
          end
          MD_NEXP0: begin
            if (c == "+" || c == "-" || is_dig(c)) begin
              ev[n[1:0]] = ev_make(EV_NUM_BYTE, c, lv_d, err_d); n = n + 3'd1;
              md_d = is_dig(c) ? MD_NEXP : MD_NEXPS;
            end else begin
              err_d = ER_EXP; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
            end
          end
          MD_NZERO, MD_NINT, MD_NFRAC, MD_NEXP: begin
            if (is_dig(c)) begin
              if (md_q == MD_NZERO) begin
                err_d = ER_INT_ZERO; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
                n = n + 3'd1;
              end else begin
                ev[n[1:0]] = ev_make(EV_NUM_BYTE, c, lv_d, err_d); n = n + 3'd1;
              end
            end else if (c == "." && (md_q == MD_NZERO || md_q == MD_NINT)) begin
              ev[n[1:0]] = ev_make(EV_NUM_BYTE, c, lv_d, err_d); n = n + 3'd1;
              md_d = MD_NFRAC0;
            end else if ((c == "e" || c == "E") && md_q != MD_NEXP) begin
              ev[n[1:0]] = ev_make(EV_NUM_BYTE, c, lv_d, err_d); n = n + 3'd1;
              md_d = MD_NEXP0;
            end else begin
              // number ends here, byte goes on as the token after the value
              ev[n[1:0]] = ev_make(EV_NUM_END, 8'h0, lv_d, err_d); n = n + 3'd1;
              md_d = MD_VALUE;
              do_val = 1'b1;
            end
          end
          MD_LIT: begin
            if (lw == 2'd3) begin
              err_d = ER_TOKEN; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
            end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
              if (ln < wlen && c == lit_char(lw, ln)) lit_d = {lw, ln + 3'd1};
              else begin
                err_d = ER_TOKEN; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
                n = n + 3'd1;
              end
            end else if (lit_ok) begin
              ev[n[1:0]] = ev_make(EV_TRUE + {2'b00, lw}, 8'h0, lv_d, err_d); n = n + 3'd1;
              md_d = MD_VALUE;
              do_val = 1'b1;
            end else begin
              err_d = ER_TOKEN; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
            end
          end
          default: ;
        endcase

        // token after a value
        if (do_val && !is_ws(c)) begin
          if (c == (top_d[1] ? 8'h7D : 8'h5D)) begin
            if (lv_d == '0) begin
              err_d = ER_CLOSES; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
              n = n + 3'd1;
            end else begin
              lv_d = lv_d - 1'b1;
              top_d = below_q;
              ev[n[1:0]] = ev_make(EV_CLOSE, 8'h0, lv_d, err_d); n = n + 3'd1;
            end
          end else if (c == ",") begin
            if (!top_d[0]) begin
              err_d = ER_COMMA_UNEXP; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
              n = n + 3'd1;
            end else md_d = MD_AFTER_COMMA;
          end else if (top_d[0]) begin
            err_d = ER_COMMA_EXP; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d);
            n = n + 3'd1;
          end else do_start = 1'b1;
        end

        if (do_start) begin
          if (top_d[1]) begin
            if (c == 8'h22) begin
              key_d = 1'b1; md_d = MD_STR;
            end else begin
              err_d = ER_QUOTE; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
            end
          end else do_vstart = 1'b1;
        end

        if (do_vstart) begin
          top_d = top_d | FL_COMMA;
          if (c == "{" || c == "[") begin
            if (lv_d >= LW'(MAX_DEPTH)) begin
              err_d = ER_DEPTH; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
            end else begin
              push_lv = 1'b1;
              push_flags = top_d;
              lv_d = lv_d + 1'b1;
              top_d = (c == "{") ? FL_OBJECT : 2'b00;
              ev[n[1:0]] = ev_make((c == "{") ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'h0, lv_d, err_d);
              n = n + 3'd1;
              md_d = MD_VALUE;
            end
          end else if (c == 8'h22) begin
            key_d = 1'b0; md_d = MD_STR;
          end else if (c == "-" || is_dig(c)) begin
            ev[n[1:0]] = ev_make(EV_NUM_BYTE, c, lv_d, err_d); n = n + 3'd1;
            md_d = (c == "-") ? MD_NSIGN : (c == "0") ? MD_NZERO : MD_NINT;
          end else if (c == "t" || c == "f" || c == "n") begin
            lit_d = {(c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2, 3'd1};
            md_d = MD_LIT;
          end else begin
            err_d = ER_TOKEN; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
          end
        end

        // re-encode a decoded code point as utf-8
        if (cp_en) begin
          if (cp < 21'h80) begin
            ev[n[1:0]] = ev_make(sk, cp[7:0], lv_d, err_d); n = n + 3'd1;
          end else if (cp < 21'h800) begin
            ev[n[1:0]] = ev_make(sk, {3'b110, cp[10:6]}, lv_d, err_d); n = n + 3'd1;
            ev[n[1:0]] = ev_make(sk, {2'b10, cp[5:0]}, lv_d, err_d); n = n + 3'd1;
          end else if (cp < 21'h10000) begin
            ev[n[1:0]] = ev_make(sk, {4'b1110, cp[15:12]}, lv_d, err_d); n = n + 3'd1;
            ev[n[1:0]] = ev_make(sk, {2'b10, cp[11:6]}, lv_d, err_d); n = n + 3'd1;
            ev[n[1:0]] = ev_make(sk, {2'b10, cp[5:0]}, lv_d, err_d); n = n + 3'd1;
          end else begin
            ev[n[1:0]] = ev_make(sk, {5'b11110, cp[20:18]}, lv_d, err_d); n = n + 3'd1;
            ev[n[1:0]] = ev_make(sk, {2'b10, cp[17:12]}, lv_d, err_d); n = n + 3'd1;
            ev[n[1:0]] = ev_make(sk, {2'b10, cp[11:6]}, lv_d, err_d); n = n + 3'd1;
            ev[n[1:0]] = ev_make(sk, {2'b10, cp[5:0]}, lv_d, err_d); n = n + 3'd1;
          end
        end
      end

      if (do_endv) begin
        if (lv_d == '0) begin
          ev[n[1:0]] = ev_make(EV_DOC_END, 8'h0, lv_d, err_d); n = n + 3'd1;
          md_d = MD_DONE;
        end else begin
          err_d = ER_END; ev[n[1:0]] = ev_make(EV_ERROR, 8'h0, lv_d, err_d); n = n + 3'd1;
        end
      end
    end
  end

  assign push_o       = n != 3'd0;
  assign bundle_o.ev  = ev;
  assign bundle_o.cnt = n;
  assign bundle_o.line = line_d;
  assign bundle_o.col  = col_d;

  // flags of the levels below the top, top level kept in top_q
  assign rd_addr = AW'(lv_d - 1'b1);

  always_ff @(posedge clk_i) begin
    if (push_lv) stack_mem[lv_q[AW-1:0]] <= push_flags;
  end

  // prefetch of the level below the next top, bypassed on a push
  always_ff @(posedge clk_i) begin
    if (push_lv) below_q <= push_flags;
    else         below_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q   <= MD_VALUE;
      lv_q   <= '0;
      top_q  <= '0;
      hex_q  <= '0;
      hcnt_q <= '0;
      hs_q   <= '0;
      u8_q   <= '0;
      lit_q  <= '0;
      err_q  <= '0;
      line_q <= '0;
      col_q  <= CntW'(1);
      key_q  <= 1'b0;
    end else begin
      md_q   <= md_d;
      lv_q   <= lv_d;
      top_q  <= top_d;
      hex_q  <= hex_d;
      hcnt_q <= hcnt_d;
      hs_q   <= hs_d;
      u8_q   <= u8_d;
      lit_q  <= lit_d;
      err_q  <= err_d;
      line_q <= line_d;
      col_q  <= col_d;
      key_q  <= key_d;
    end
  end

endmodule

// File: rtl/jst_queue.sv
// ----------------------------------------------------------------------------
// jst_queue
// Two-entry queue of event groups between the parser and the output side.
// ----------------------------------------------------------------------------
module jst_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jst_pkg::bundle_t data_i,
  input  logic             pop_i,
  output logic             nonempty_o,
  output logic             full_o,
  output jst_pkg::bundle_t head_o
);
  import jst_pkg::*;

  bundle_t    slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign nonempty_o = cnt_q != 2'd0;
  assign full_o     = cnt_q == 2'd2;
  assign head_o     = slot_q[rd_q];

endmodule

// File: rtl/jst_back.sv
// ----------------------------------------------------------------------------
// jst_back
// Output side: walks through the events of the head group into the output
// register, one per cycle unless out_stall_i holds a valid output.
// ----------------------------------------------------------------------------
module jst_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             nonempty_i,
  input  jst_pkg::bundle_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output jst_pkg::out_t    out_data_o
);
  import jst_pkg::*;

  logic [1:0] idx_q;
  logic       ov_q;
  out_t       out_q;
  logic       load, last;
  ev_t        cur;

  assign cur  = head_i.ev[idx_q];
  assign last = ({1'b0, idx_q} + 3'd1) == head_i.cnt;
  assign load = nonempty_i && (!ov_q || !out_stall_i);
  assign pop_o = load && last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.event_kind    <= cur.kind;
      out_q.data_byte     <= cur.data;
      out_q.nest_depth    <= cur.depth;
      out_q.error_code    <= cur.err;
      out_q.line_number   <= head_i.line;
      out_q.column_number <= head_i.col;
      out_q.last_of_run   <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/json_stream_tokenizer_core.sv
// ----------------------------------------------------------------------------
// json_stream_tokenizer_core
// Streaming JSON tokenizer and validator, one text byte per item.
// ----------------------------------------------------------------------------
// Input channel: in_data_i carries a text byte or the end-of-text mark; an
// item is taken on a rising edge with in_valid_i high and in_stall_o low.
// Output channel: token events, 0 to 4 per input item, the last one of an
// item flagged by last_of_run; taken when out_valid_o is high and out_stall_i
// is low.
// Flow: each item is parsed in the cycle it is taken and its event group is
// written into the queue; its events then pass from the queue head into the
// output register. The input side runs at one item per cycle while in_stall_o
// is low; the output register moves one event per cycle while not stalled.
// A two-entry event-group queue sits between parser and output register; when
// the receiver stalls the queue fills and in_stall_o rises.
// After the first error (event kind 14) or the document end, further items are
// taken and dropped without result.
// Reset clears the parser to expect a value at the top level, with line 0,
// column 1, and empties the queue and output register.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_core #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  jst_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output jst_pkg::out_t  out_data_o
);
  import jst_pkg::*;

  logic    acc, push, pop, nonempty, full;
  bundle_t bundle, head;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  jst_front #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .in_i     (in_data_i),
    .push_o   (push),
    .bundle_o (bundle)
  );

  jst_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (bundle),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .full_o     (full),
    .head_o     (head)
  );

  jst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
